### hdl/wbpl_pkg.sv
// ----------------------------------------------------------------------------
// wbpl_pkg
// Shared types, codes and constants for the word buffer with position and
// limit pointers.
// ----------------------------------------------------------------------------
package wbpl_pkg;

   localparam int DEFAULT_CAPACITY = 256;

   localparam int ACTION_W = 4;
   localparam int INDEX_W  = 8;
   localparam int VALUE_W  = 32;
   localparam int MARK_W   = 9;
   localparam int ERR_W    = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUT       = 4'd0,
      ACT_GET       = 4'd1,
      ACT_PUT_AT    = 4'd2,
      ACT_GET_AT    = 4'd3,
      ACT_CLEAR     = 4'd4,
      ACT_FLIP      = 4'd5,
      ACT_REWIND    = 4'd6,
      ACT_COMPACT   = 4'd7,
      ACT_SET_POS   = 4'd8,
      ACT_SET_LIMIT = 4'd9
   } action_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_UNDER = 2'd1,
      ERR_OVER  = 2'd2,
      ERR_RANGE = 2'd3
   } err_type;

   // What the decision unit asks of the sequencer for one action
   typedef struct packed {
      logic    wr;
      logic    rd;
      logic    move;
      err_type err;
   } op_type;

endpackage

### hdl/wbpl_store.sv
// ----------------------------------------------------------------------------
// wbpl_store
// Word store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wbpl_store #(
   parameter int CAPACITY = wbpl_pkg::DEFAULT_CAPACITY
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
   input  logic [wbpl_pkg::VALUE_W-1:0]           wr_data,
   input  logic                                   rd_en,
   input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
   output logic [wbpl_pkg::VALUE_W-1:0]           rd_data
);
   import wbpl_pkg::*;

   logic [VALUE_W-1:0] mem_ff [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/wbpl_step.sv
// ----------------------------------------------------------------------------
// wbpl_step
// Pointer unit: checks one action against position and limit and gives the
// next pointers, the store address and the store operation to run.
// ----------------------------------------------------------------------------
module wbpl_step #(
   parameter int CAPACITY = wbpl_pkg::DEFAULT_CAPACITY
) (
   input  logic [wbpl_pkg::ACTION_W-1:0]          action,
   input  logic [wbpl_pkg::INDEX_W-1:0]           index,
   input  logic [wbpl_pkg::MARK_W-1:0]            new_mark,
   input  logic [$clog2(CAPACITY+1)-1:0]          cursor,
   input  logic [$clog2(CAPACITY+1)-1:0]          end_mark,
   output logic [$clog2(CAPACITY+1)-1:0]          next_cursor,
   output logic [$clog2(CAPACITY+1)-1:0]          next_end,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] addr,
   output wbpl_pkg::op_type                       op
);
   import wbpl_pkg::*;

   localparam int PTR_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW     = (PTR_W > MARK_W) ? PTR_W : MARK_W;

   logic [CW-1:0] cur_x;
   logic [CW-1:0] end_x;
   logic [CW-1:0] idx_x;
   logic [CW-1:0] mark_x;
   logic [CW-1:0] cap_x;
   logic          has_room;
   logic          idx_ok;

   assign cur_x    = CW'(cursor);
   assign end_x    = CW'(end_mark);
   assign idx_x    = CW'(index);
   assign mark_x   = CW'(new_mark);
   assign cap_x    = CW'(CAPACITY);
   // limit never exceeds capacity, so below the limit is inside the store
   assign has_room = (cursor < end_mark);
   assign idx_ok   = (idx_x < end_x);

   always_comb begin
      next_cursor = cursor;
      next_end    = end_mark;
      addr        = cursor[ADDR_W-1:0];
      op          = '{wr: 1'b0, rd: 1'b0, move: 1'b0, err: ERR_OK};
      case (action_type'(action))
         ACT_PUT: begin
            if (has_room) begin
               op.wr       = 1'b1;
               next_cursor = cursor + 1'b1;
            end else begin
               op.err = ERR_OVER;
            end
         end
         ACT_GET: begin
            if (has_room) begin
               op.rd       = 1'b1;
               next_cursor = cursor + 1'b1;
            end else begin
               op.err = ERR_UNDER;
            end
         end
         ACT_PUT_AT: begin
            addr = idx_x[ADDR_W-1:0];
            if (idx_ok) begin
               op.wr = 1'b1;
            end else begin
               op.err = ERR_RANGE;
            end
         end
         ACT_GET_AT: begin
            addr = idx_x[ADDR_W-1:0];
            if (idx_ok) begin
               op.rd = 1'b1;
            end else begin
               op.err = ERR_RANGE;
            end
         end
         ACT_CLEAR: begin
            next_cursor = '0;
            next_end    = PTR_W'(CAPACITY);
         end
         ACT_FLIP: begin
            next_end    = cursor;
            next_cursor = '0;
         end
         ACT_REWIND: begin
            next_cursor = '0;
         end
         ACT_COMPACT: begin
            next_cursor = end_mark - cursor;
            next_end    = PTR_W'(CAPACITY);
            // nothing to move when the words already sit at the start
            op.move     = (end_mark != cursor) && (cursor != '0);
         end
         ACT_SET_POS: begin
            if (mark_x > end_x) begin
               op.err = ERR_RANGE;
            end else begin
               next_cursor = mark_x[PTR_W-1:0];
            end
         end
         ACT_SET_LIMIT: begin
            if (mark_x > cap_x) begin
               op.err = ERR_RANGE;
            end else begin
               next_end = mark_x[PTR_W-1:0];
               if (cur_x > mark_x) begin
                  next_cursor = mark_x[PTR_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### hdl/wbpl_seq.sv
// ----------------------------------------------------------------------------
// wbpl_seq
// Sequencer: clearing pass after reset, action execution through the pointer
// unit, store reads and the word-by-word compact move.
// ----------------------------------------------------------------------------
module wbpl_seq #(
   parameter int CAPACITY = wbpl_pkg::DEFAULT_CAPACITY
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [wbpl_pkg::ACTION_W-1:0]          req_action,
   input  logic [wbpl_pkg::INDEX_W-1:0]           req_index,
   input  logic signed [wbpl_pkg::VALUE_W-1:0]    req_value,
   input  logic [wbpl_pkg::MARK_W-1:0]            req_new_mark,
   output logic                                   rsp_strobe,
   output logic signed [wbpl_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic [wbpl_pkg::ERR_W-1:0]             rsp_error,
   output logic [wbpl_pkg::MARK_W-1:0]            rsp_position_now,
   output logic [wbpl_pkg::MARK_W-1:0]            rsp_limit_now,
   output logic [wbpl_pkg::MARK_W-1:0]            rsp_remaining_now,
   output logic                                   mem_wr_en,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_wr_addr,
   output logic [wbpl_pkg::VALUE_W-1:0]           mem_wr_data,
   output logic                                   mem_rd_en,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_rd_addr,
   input  logic [wbpl_pkg::VALUE_W-1:0]           mem_rd_data
);
   import wbpl_pkg::*;

   localparam int PTR_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW     = (PTR_W > MARK_W) ? PTR_W : MARK_W;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_MOVE
   } state_type;

   state_type            state_ff, state_in;
   logic [PTR_W-1:0]     cursor_ff, cursor_in;
   logic [PTR_W-1:0]     end_ff, end_in;
   logic [ACTION_W-1:0]  act_ff, act_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic [MARK_W-1:0]    mark_ff, mark_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [ADDR_W-1:0]    src_ff, src_in;
   logic [ADDR_W-1:0]    dst_ff, dst_in;
   logic [PTR_W-1:0]     left_ff, left_in;
   logic                 pend_ff, pend_in;
   logic                 strobe_ff, strobe_in;
   logic [VALUE_W-1:0]   rdval_ff, rdval_in;
   err_type              err_ff, err_in;
   logic [MARK_W-1:0]    pos_ff, pos_in;
   logic [MARK_W-1:0]    lim_ff, lim_in;
   logic [MARK_W-1:0]    rem_ff, rem_in;

   logic [PTR_W-1:0]     step_cursor;
   logic [PTR_W-1:0]     step_end;
   logic [ADDR_W-1:0]    step_addr;
   op_type               step_op;
   logic [CW-1:0]        pos_x;
   logic [CW-1:0]        lim_x;
   logic [CW-1:0]        rem_x;

   wbpl_step #(
      .CAPACITY (CAPACITY)
   ) u_step (
      .action      (act_ff),
      .index       (idx_ff),
      .new_mark    (mark_ff),
      .cursor      (cursor_ff),
      .end_mark    (end_ff),
      .next_cursor (step_cursor),
      .next_end    (step_end),
      .addr        (step_addr),
      .op          (step_op)
   );

   always_comb begin
      state_in    = state_ff;
      cursor_in   = cursor_ff;
      end_in      = end_ff;
      act_in      = act_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      mark_in     = mark_ff;
      clr_in      = clr_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      left_in     = left_ff;
      pend_in     = pend_ff;
      strobe_in   = 1'b0;
      rdval_in    = rdval_ff;
      err_in      = err_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(CAPACITY - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               act_in   = req_action;
               idx_in   = req_index;
               val_in   = req_value;
               mark_in  = req_new_mark;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cursor_in   = step_cursor;
            end_in      = step_end;
            err_in      = step_op.err;
            rdval_in    = '0;
            mem_wr_en   = step_op.wr;
            mem_wr_addr = step_addr;
            mem_wr_data = val_ff;
            mem_rd_en   = step_op.rd;
            mem_rd_addr = step_addr;
            if (step_op.rd) begin
               state_in = ST_READ;
            end else if (step_op.move) begin
               src_in   = cursor_ff[ADDR_W-1:0];
               dst_in   = '0;
               left_in  = end_ff - cursor_ff;
               pend_in  = 1'b0;
               state_in = ST_MOVE;
            end else begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_READ: begin
            rdval_in  = mem_rd_data;
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_MOVE: begin
            // write the word fetched last cycle while fetching the next one
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = dst_ff;
               mem_wr_data = mem_rd_data;
               dst_in      = dst_ff + 1'b1;
            end
            if (left_ff != '0) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = src_ff;
               src_in      = src_ff + 1'b1;
               left_in     = left_ff - 1'b1;
               pend_in     = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  strobe_in = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pos_x  = CW'(cursor_in);
   assign lim_x  = CW'(end_in);
   assign rem_x  = CW'(end_in - cursor_in);
   assign pos_in = strobe_in ? pos_x[MARK_W-1:0] : pos_ff;
   assign lim_in = strobe_in ? lim_x[MARK_W-1:0] : lim_ff;
   assign rem_in = strobe_in ? rem_x[MARK_W-1:0] : rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         cursor_ff <= '0;
         end_ff    <= PTR_W'(CAPACITY);
         clr_ff    <= '0;
         left_ff   <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         end_ff    <= end_in;
         clr_ff    <= clr_in;
         left_ff   <= left_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
      act_ff   <= act_in;
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      mark_ff  <= mark_in;
      src_ff   <= src_in;
      dst_ff   <= dst_in;
      rdval_ff <= rdval_in;
      err_ff   <= err_in;
      pos_ff   <= pos_in;
      lim_ff   <= lim_in;
      rem_ff   <= rem_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = strobe_ff;
   assign rsp_read_value    = rdval_ff;
   assign rsp_error         = err_ff;
   assign rsp_position_now  = pos_ff;
   assign rsp_limit_now     = lim_ff;
   assign rsp_remaining_now = rem_ff;

endmodule

### hdl/word_buffer_position_limit.sv
// ----------------------------------------------------------------------------
// word_buffer_position_limit
// Word store with position and limit pointers, buffer-style actions.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_action, req_index, req_value and req_new_mark and raise start;
//   the beat is taken on a clock edge where start is high and busy is low.
//   Each beat gives exactly one result, shown on the rsp_ ports for a single
//   cycle with rsp_strobe high; the receiver must take it in that cycle.
// Flow, from the accepting edge to the strobe cycle:
//   put, absolute put, pointer actions and errors: the execute state only;
//   get and absolute get: execute, then a read state (one registered store read);
//   compact that moves N words: execute, then a move state, one word per
//   cycle through the single store read/write port pair; a compact with
//   nothing to move (position already 0, or nothing remaining) skips the move.
//   busy drops in the strobe cycle, so a new beat may be taken there.
// Reset: synchronous. After reset the block zeroes the store in a clearing
//   pass with busy high; position is 0 and limit CAPACITY.
// ----------------------------------------------------------------------------
module word_buffer_position_limit #(
   parameter int CAPACITY = wbpl_pkg::DEFAULT_CAPACITY
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [wbpl_pkg::ACTION_W-1:0]          req_action,
   input  logic [wbpl_pkg::INDEX_W-1:0]           req_index,
   input  logic signed [wbpl_pkg::VALUE_W-1:0]    req_value,
   input  logic [wbpl_pkg::MARK_W-1:0]            req_new_mark,
   output logic                                   rsp_strobe,
   output logic signed [wbpl_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic [wbpl_pkg::ERR_W-1:0]             rsp_error,
   output logic [wbpl_pkg::MARK_W-1:0]            rsp_position_now,
   output logic [wbpl_pkg::MARK_W-1:0]            rsp_limit_now,
   output logic [wbpl_pkg::MARK_W-1:0]            rsp_remaining_now
);
   import wbpl_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [VALUE_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [VALUE_W-1:0] mem_rd_data;

   wbpl_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_index         (req_index),
      .req_value         (req_value),
      .req_new_mark      (req_new_mark),
      .rsp_strobe        (rsp_strobe),
      .rsp_read_value    (rsp_read_value),
      .rsp_error         (rsp_error),
      .rsp_position_now  (rsp_position_now),
      .rsp_limit_now     (rsp_limit_now),
      .rsp_remaining_now (rsp_remaining_now),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   wbpl_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

### hdl/wbpl_checker.sv
// ----------------------------------------------------------------------------
// wbpl_checker
// Port-level checks on the word buffer, bound to the top level.
// ----------------------------------------------------------------------------
module wbpl_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   start,
   input logic                                   busy,
   input logic                                   rsp_strobe,
   input logic signed [wbpl_pkg::VALUE_W-1:0]    rsp_read_value,
   input logic [wbpl_pkg::ERR_W-1:0]             rsp_error,
   input logic [wbpl_pkg::MARK_W-1:0]            rsp_position_now,
   input logic [wbpl_pkg::MARK_W-1:0]            rsp_limit_now,
   input logic [wbpl_pkg::MARK_W-1:0]            rsp_remaining_now
);
   import wbpl_pkg::*;

   // an accepted beat keeps the block busy for at least the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted beat");

   // a result only ends a busy period
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without work in progress");

   // one result per beat: never two strobes in a row
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe repeated");

   a_remaining: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         rsp_remaining_now == MARK_W'(rsp_limit_now - rsp_position_now))
      else $error("remaining count does not match limit minus position");

   a_error_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error != ERR_OK) |-> rsp_read_value == '0)
      else $error("read data on a failed action");

endmodule

bind word_buffer_position_limit wbpl_checker u_wbpl_checker (.*);
